// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file ost_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Clocked check that also holds across reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

// ===== hdl/ost_pkg.sv =====
package ost_pkg;

    // Operation codes of an input item.
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_WALK = 1'b1;

    // Kinds of result item.
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_ENTRY = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // Width of the walk selection mask.
    localparam int MASK_BITS = 32;

    // One input item.
    typedef struct packed {
        logic        opcode;
        logic        use_shadow_list;
        logic [31:0] order_key;
        logic [1:0]  sort_mode;
        logic [4:0]  func_set;
        logic [4:0]  first_slot;
        logic [31:0] select_mask;
    } ost_in_t;

    // One result item.
    typedef struct packed {
        logic [1:0] result_kind;
        logic [4:0] slot_id;
        logic       table_full;
        logic       depth_sorted;
        logic [4:0] slot_func_set;
        logic       last;
    } ost_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_step;
        logic claim;
        logic ins_init;
        logic ins_shift;
        logic ins_place;
        logic walk_init;
        logic walk_step;
        logic out_add;
        logic out_full;
        logic out_end;
    } ost_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_walk;
        logic scan_over;
        logic slot_busy;
        logic len_zero;
        logic key_greater;
        logic at_front;
        logic walk_last;
        logic walk_stall;
        logic out_free;
    } ost_stat_t;

endpackage

// ===== hdl/ost_ctrl.sv =====
module ost_ctrl
    import ost_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ost_stat_t stat,
    output ost_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_DECODE    = 4'd1;
    localparam logic [3:0] ST_SCAN      = 4'd2;
    localparam logic [3:0] ST_INS_START = 4'd3;
    localparam logic [3:0] ST_INS_LOOP  = 4'd4;
    localparam logic [3:0] ST_INS_PLACE = 4'd5;
    localparam logic [3:0] ST_ADD_RESP  = 4'd6;
    localparam logic [3:0] ST_FULL_RESP = 4'd7;
    localparam logic [3:0] ST_WALK_LOOP = 4'd8;
    localparam logic [3:0] ST_WALK_END  = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // An item is taken only while no earlier item is in progress.
    assign s_ready = (state_reg == ST_IDLE);

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (stat.is_walk) begin
                    cmd.walk_init = 1'b1;
                    state_next    = stat.len_zero ? ST_WALK_END : ST_WALK_LOOP;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.scan_over) begin
                    state_next = ST_FULL_RESP;
                end else if (stat.slot_busy) begin
                    cmd.scan_step = 1'b1;
                end else begin
                    cmd.claim  = 1'b1;
                    state_next = ST_INS_START;
                end
            end
            ST_INS_START: begin
                cmd.ins_init = 1'b1;
                state_next   = stat.len_zero ? ST_INS_PLACE : ST_INS_LOOP;
            end
            ST_INS_LOOP: begin
                if (stat.key_greater) begin
                    cmd.ins_shift = 1'b1;
                    if (stat.at_front) begin
                        state_next = ST_INS_PLACE;
                    end
                end else begin
                    cmd.ins_place = 1'b1;
                    state_next    = ST_ADD_RESP;
                end
            end
            ST_INS_PLACE: begin
                cmd.ins_place = 1'b1;
                state_next    = ST_ADD_RESP;
            end
            ST_ADD_RESP: begin
                if (stat.out_free) begin
                    cmd.out_add = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_FULL_RESP: begin
                if (stat.out_free) begin
                    cmd.out_full = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_WALK_LOOP: begin
                if (!stat.walk_stall) begin
                    cmd.walk_step = 1'b1;
                    if (stat.walk_last) begin
                        state_next = ST_WALK_END;
                    end
                end
            end
            ST_WALK_END: begin
                if (stat.out_free) begin
                    cmd.out_end = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/ost_datapath.sv =====
module ost_datapath
    import ost_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  ost_in_t   s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output ost_out_t  m_data,
    input  ost_cmd_t  cmd,
    output ost_stat_t stat
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = (SW + 1 > 6) ? SW + 1 : 6;
    localparam int LW = $clog2(SLOTS + 1);
    localparam int AW = SW + 1;
    localparam int MD = 2 * (1 << SW);

    // One list entry carries the slot and a copy of its stored fields.
    typedef struct packed {
        logic [31:0]   key;
        logic          depth;
        logic [4:0]    fset;
        logic [SW-1:0] slot;
    } entry_t;

    localparam int EW = $bits(entry_t);

    // Captured item.
    logic                 op_reg;
    logic                 shadow_reg;
    logic [31:0]          key_reg;
    logic                 depth_reg;
    logic [4:0]           fset_reg;
    logic [MASK_BITS-1:0] mask_reg;

    // Slot search and list walking state.
    logic [CW-1:0]    cnt_reg;
    logic [SW-1:0]    slot_reg;
    logic [SLOTS-1:0] act_reg;
    logic [LW-1:0]    len_reg [2];
    logic [LW-1:0]    idx_reg;

    // Both lists share one memory, the list select being the top address bit.
    logic [EW-1:0] list_mem [MD];
    entry_t        rd_data_reg;

    // Walk entry held back until it is known whether it is the last.
    entry_t   pend_reg;
    logic     pend_v_reg;
    ost_out_t out_reg;
    logic     out_valid_reg;

    logic [LW-1:0] cur_len;
    logic [LW-1:0] idx_inc;
    entry_t        entry_new;
    logic          rd_en;
    logic [LW-1:0] rd_idx;
    logic          wr_en;
    logic [LW-1:0] wr_idx;
    entry_t        wr_data;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [6:0]    walk_slot;
    logic          walk_sel;
    logic          out_free;
    logic          out_load;
    ost_out_t      out_next;

    function automatic ost_out_t entry_result(entry_t e, logic is_last);
        ost_out_t r;
        r.result_kind   = KIND_ENTRY;
        r.slot_id       = 5'(e.slot);
        r.table_full    = 1'b0;
        r.depth_sorted  = e.depth;
        r.slot_func_set = e.fset;
        r.last          = is_last;
        return r;
    endfunction

    // Status towards the controller.
    assign cur_len   = len_reg[shadow_reg];
    assign idx_inc   = idx_reg + LW'(1);
    assign walk_slot = 7'(rd_data_reg.slot);
    assign walk_sel  = (walk_slot < 7'(MASK_BITS)) && mask_reg[walk_slot[4:0]];
    assign out_free  = !out_valid_reg || m_ready;

    always_comb begin
        stat.is_walk     = (op_reg == OP_WALK);
        stat.scan_over   = (cnt_reg >= CW'(SLOTS));
        stat.slot_busy   = act_reg[cnt_reg[SW-1:0]];
        stat.len_zero    = (cur_len == '0);
        stat.key_greater = (rd_data_reg.key > key_reg);
        stat.at_front    = (idx_reg == LW'(1));
        stat.walk_last   = (idx_inc == cur_len);
        stat.walk_stall  = walk_sel && pend_v_reg && !out_free;
        stat.out_free    = out_free;
    end

    // Memory port control for insertion and walking.
    always_comb begin
        entry_new.key   = key_reg;
        entry_new.depth = depth_reg;
        entry_new.fset  = fset_reg;
        entry_new.slot  = slot_reg;
        rd_en   = 1'b0;
        rd_idx  = '0;
        wr_en   = 1'b0;
        wr_idx  = idx_reg;
        wr_data = entry_new;
        if (cmd.ins_init) begin
            rd_en  = (cur_len != '0);
            rd_idx = cur_len - LW'(1);
        end else if (cmd.ins_shift) begin
            wr_en   = 1'b1;
            wr_data = rd_data_reg;
            rd_en   = (idx_reg != LW'(1));
            rd_idx  = idx_reg - LW'(2);
        end else if (cmd.ins_place) begin
            wr_en = 1'b1;
        end else if (cmd.walk_init) begin
            rd_en  = (cur_len != '0);
            rd_idx = '0;
        end else if (cmd.walk_step) begin
            rd_en  = !stat.walk_last;
            rd_idx = idx_inc;
        end
        rd_addr = {shadow_reg, rd_idx[SW-1:0]};
        wr_addr = {shadow_reg, wr_idx[SW-1:0]};
    end

    // List memory with a registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            list_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= list_mem[rd_addr];
        end
    end

    // Result selection.
    always_comb begin
        out_load = 1'b0;
        out_next = out_reg;
        if (cmd.walk_step && walk_sel && pend_v_reg) begin
            out_load = 1'b1;
            out_next = entry_result(pend_reg, 1'b0);
        end else if (cmd.out_end) begin
            out_load = 1'b1;
            if (pend_v_reg) begin
                out_next = entry_result(pend_reg, 1'b1);
            end else begin
                out_next = '0;
                out_next.result_kind = KIND_EMPTY;
                out_next.last        = 1'b1;
            end
        end else if (cmd.out_add) begin
            out_load = 1'b1;
            out_next = '0;
            out_next.result_kind = KIND_ADD;
            out_next.slot_id     = 5'(slot_reg);
            out_next.last        = 1'b1;
        end else if (cmd.out_full) begin
            out_load = 1'b1;
            out_next = '0;
            out_next.result_kind = KIND_ADD;
            out_next.table_full  = 1'b1;
            out_next.last        = 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= s_data.opcode;
            shadow_reg <= s_data.use_shadow_list;
            key_reg    <= s_data.order_key;
            depth_reg  <= (s_data.sort_mode == 2'd0);
            fset_reg   <= s_data.func_set;
            mask_reg   <= s_data.select_mask;
            cnt_reg    <= CW'(s_data.first_slot);
        end else if (cmd.scan_step) begin
            cnt_reg <= cnt_reg + CW'(1);
        end
        if (cmd.claim) begin
            slot_reg <= cnt_reg[SW-1:0];
        end
        if (cmd.ins_init) begin
            idx_reg <= cur_len;
        end else if (cmd.ins_shift) begin
            idx_reg <= idx_reg - LW'(1);
        end else if (cmd.walk_init) begin
            idx_reg <= '0;
        end else if (cmd.walk_step) begin
            idx_reg <= idx_inc;
        end
        if (cmd.walk_step && walk_sel) begin
            pend_reg <= rd_data_reg;
        end
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    // Control registers cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg       <= '0;
            len_reg[0]    <= '0;
            len_reg[1]    <= '0;
            pend_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.claim) begin
                act_reg[cnt_reg[SW-1:0]] <= 1'b1;
            end
            if (cmd.ins_place) begin
                len_reg[shadow_reg] <= cur_len + LW'(1);
            end
            if (cmd.walk_init) begin
                pend_v_reg <= 1'b0;
            end else if (cmd.walk_step && walk_sel) begin
                pend_v_reg <= 1'b1;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== hdl/ordered_slot_table_unit.sv =====
// Add: the free-slot scan steps past each occupied slot from first_slot, then list entries
// with a greater key are moved up one place before the new entry is placed and the answer
// is presented; a full table is answered once the scan has passed the last slot.
// Walk: the list entries are read in order, with stalls while a result waits on m_ready.
// One item at a time; the scan counter and the single list memory set the rate.
// Reset (aresetn low, synchronous) frees all slots and empties both lists; list
// memory contents are left as they are and need no clearing pass.
module ordered_slot_table_unit
    import ost_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ost_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ost_out_t m_data
);

    ost_cmd_t  cmd;
    ost_stat_t stat;

    // Sequencing of the add and walk operations.
    ost_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Slot table, list memory and output register.
    ost_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

// ===== hdl/ost_checker.sv =====
`include "assert_macros.svh"

module ost_checker
    import ost_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input ost_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input ost_out_t m_data
);

    // A result waiting for the sink holds steady.
    `ASSERT_CLK(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "result changed while stalled")

    // Reset leaves the block ready and with no result pending.
    `ASSERT_ALWAYS(a_reset_state, !aresetn |=> s_ready && !m_valid, "reset state wrong")

    // Add answers and empty walks are single results.
    `ASSERT_CLK(a_single_last, m_valid && (m_data.result_kind == KIND_ADD || m_data.result_kind == KIND_EMPTY) |-> m_data.last, "single result without last")

    // A full table answer reports slot zero as an add answer.
    `ASSERT_CLK(a_full_answer, m_valid && m_data.table_full |-> m_data.slot_id == 5'd0 && m_data.result_kind == KIND_ADD, "malformed full answer")

    // After an input transfer no further item is taken in the next cycle.
    `ASSERT_CLK(a_one_item, s_valid && s_ready |=> !s_ready, "second item taken too early")

endmodule

bind ordered_slot_table_unit ost_checker u_ost_checker (.*);

// ===== test/slot_table_checker.sv =====
`timescale 1ns / 100ps

module slot_table_checker
    import ost_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  ost_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  ost_out_t m_data,
    output int       error_count,
    output int       pending
);

    localparam int SLOT_COUNT = MASK_BITS;

    // Mirror of the slot table: index 0 of the lists is the scene list, 1 the shadow list.
    logic [SLOT_COUNT-1:0] slot_used;
    logic [SLOT_COUNT-1:0] depth_mask;
    logic [31:0]           key_of [SLOT_COUNT];
    logic [4:0]            set_of [SLOT_COUNT];
    logic [4:0]            order_list [2][SLOT_COUNT];
    int                    list_len [2];

    // Results still owed by the block, oldest first.
    ost_out_t due_results[$];
    ost_out_t want;

    // Append one expected result behind those already owed.
    function automatic void queue_result(input ost_out_t r);
        due_results.insert(due_results.size(), r);
    endfunction

    // Work out the results of one accepted item and update the mirrored table.
    function automatic void model_item(input ost_in_t item);
        int       sel;
        int       slot;
        int       pos;
        int       i;
        int       hits;
        int       seen;
        logic [4:0] s;
        ost_out_t r;
        sel = item.use_shadow_list ? 1 : 0;
        r = '0;
        if (item.opcode == OP_ADD) begin
            r.result_kind = KIND_ADD;
            r.last = 1'b1;
            slot = item.first_slot;
            while (slot < SLOT_COUNT && slot_used[slot])
                slot++;
            if (slot >= SLOT_COUNT) begin
                r.table_full = 1'b1;
            end else begin
                slot_used[slot] = 1'b1;
                key_of[slot] = item.order_key;
                set_of[slot] = item.func_set;
                // The new slot goes after every entry whose key is not greater.
                pos = 0;
                while (pos < list_len[sel] && key_of[order_list[sel][pos]] <= item.order_key)
                    pos++;
                for (i = list_len[sel]; i > pos; i--)
                    order_list[sel][i] = order_list[sel][i-1];
                order_list[sel][pos] = slot[4:0];
                list_len[sel]++;
                if (item.sort_mode == 2'd0)
                    depth_mask[slot] = 1'b1;
                r.slot_id = slot[4:0];
            end
            queue_result(r);
        end else begin
            // Count the selected entries first so that the final one can carry last.
            hits = 0;
            for (i = 0; i < list_len[sel]; i++)
                if (item.select_mask[order_list[sel][i]])
                    hits++;
            if (hits == 0) begin
                r.result_kind = KIND_EMPTY;
                r.last = 1'b1;
                queue_result(r);
            end else begin
                seen = 0;
                for (i = 0; i < list_len[sel]; i++) begin
                    s = order_list[sel][i];
                    if (item.select_mask[s]) begin
                        seen++;
                        r.result_kind = KIND_ENTRY;
                        r.slot_id = s;
                        r.table_full = 1'b0;
                        r.depth_sorted = depth_mask[s];
                        r.slot_func_set = set_of[s];
                        r.last = (seen == hits);
                        queue_result(r);
                    end
                end
            end
        end
    endfunction

    task automatic check_field(input string name, input logic [4:0] exp_val,
                               input logic [4:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            error_count = error_count + 1;
        end
    endtask

    // Compare each result transfer with the oldest expectation, then model new input transfers.
    always @(posedge aclk) begin
        if (!aresetn) begin
            slot_used = '0;
            depth_mask = '0;
            list_len[0] = 0;
            list_len[1] = 0;
            due_results.delete();
            error_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result transfer, actual kind %0d slot %0d",
                             $time, m_data.result_kind, m_data.slot_id);
                    error_count = error_count + 1;
                end else begin
                    want = due_results.pop_front();
                    check_field("result_kind", 5'(want.result_kind),
                                5'(m_data.result_kind));
                    check_field("slot_id", want.slot_id, m_data.slot_id);
                    check_field("table_full", 5'(want.table_full), 5'(m_data.table_full));
                    check_field("depth_sorted", 5'(want.depth_sorted),
                                5'(m_data.depth_sorted));
                    check_field("slot_func_set", want.slot_func_set, m_data.slot_func_set);
                    check_field("last", 5'(want.last), 5'(m_data.last));
                end
            end
            if (s_valid && s_ready)
                model_item(s_data);
        end
        pending = due_results.size();
    end

endmodule

// ===== test/tb_ordered_slot_table_unit.sv =====
`timescale 1ns / 100ps

module tb_ordered_slot_table_unit;
    import ost_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 80;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    ost_in_t  s_data;
    logic     m_valid;
    logic     m_ready = 1'b0;
    ost_out_t m_data;

    int errors;
    int pending;
    int send_idle_pct = 0;
    int ready_stall_pct = 0;
    int quiet_cycles = 0;

    ordered_slot_table_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    slot_table_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .error_count (errors),
        .pending     (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // The receiver stalls at random, at the rate of the current phase.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= ready_stall_pct);
    end

    // End the run if nothing is transferred for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("ordered_slot_table_unit test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic ost_in_t add_item(input logic shadow, input logic [31:0] key,
                                         input logic [1:0] mode, input logic [4:0] fset,
                                         input logic [4:0] first);
        ost_in_t item;
        item.opcode = OP_ADD;
        item.use_shadow_list = shadow;
        item.order_key = key;
        item.sort_mode = mode;
        item.func_set = fset;
        item.first_slot = first;
        item.select_mask = $urandom;
        return item;
    endfunction

    function automatic ost_in_t walk_item(input logic shadow, input logic [31:0] mask);
        ost_in_t item;
        logic [31:0] rnd;
        rnd = $urandom;
        item.opcode = OP_WALK;
        item.use_shadow_list = shadow;
        item.order_key = $urandom;
        item.sort_mode = rnd[1:0];
        item.func_set = rnd[6:2];
        item.first_slot = rnd[11:7];
        item.select_mask = mask;
        return item;
    endfunction

    // Present one item from a falling edge and hold it until it is transferred.
    task automatic send_item(input ost_in_t item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    initial begin
        ost_in_t     item;
        logic [31:0] rnd;
        int          phase;
        int          n;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part: empty lists, key extremes, equal keys, a full search and mask edges.
        send_item(walk_item(1'b0, 32'hFFFF_FFFF));
        send_item(walk_item(1'b1, 32'hFFFF_FFFF));
        send_item(add_item(1'b0, 32'h0000_0000, 2'd0, 5'd0, 5'd0));
        send_item(add_item(1'b0, 32'hFFFF_FFFF, 2'd3, 5'd31, 5'd31));
        send_item(add_item(1'b0, 32'h0000_0000, 2'd1, 5'd19, 5'd0));
        send_item(add_item(1'b1, 32'd100, 2'd0, 5'd20, 5'd31));
        send_item(add_item(1'b1, 32'd100, 2'd2, 5'd5, 5'd30));
        send_item(add_item(1'b1, 32'd50, 2'd0, 5'd7, 5'd0));
        send_item(add_item(1'b1, 32'd100, 2'd0, 5'd1, 5'd2));
        send_item(walk_item(1'b0, 32'hFFFF_FFFF));
        send_item(walk_item(1'b1, 32'hFFFF_FFFF));
        send_item(walk_item(1'b0, 32'h0000_0000));
        send_item(walk_item(1'b0, 32'h8000_0001));
        send_item(walk_item(1'b1, 32'h4000_0004));
        send_item(add_item(1'b0, 32'h7FFF_FFFF, 2'd0, 5'd10, 5'd16));
        send_item(add_item(1'b1, 32'hFFFF_FFFF, 2'd3, 5'd31, 5'd31));
        send_item(walk_item(1'b0, 32'hFFFF_0000));
        send_item(walk_item(1'b1, 32'h0000_FFFF));

        // Random part in four phases of handshake pressure.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
                1: begin send_idle_pct = 71; ready_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  ready_stall_pct = 71; end
                default: begin send_idle_pct = 34; ready_stall_pct = 34; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                rnd = $urandom;
                item.opcode = ($urandom_range(0, 99) < 30) ? OP_ADD : OP_WALK;
                item.use_shadow_list = rnd[0];
                item.sort_mode = rnd[2:1];
                item.func_set = rnd[7:3];
                item.first_slot = rnd[12:8];
                // Small keys and keys just above 2**31 repeat; others are random or extreme.
                case ($urandom_range(0, 3))
                    0: item.order_key = {29'd0, rnd[15:13]};
                    1: item.order_key = $urandom;
                    2: item.order_key = rnd[16] ? 32'hFFFF_FFFF : 32'h0000_0000;
                    default: item.order_key = {1'b1, 28'd0, rnd[19:17]};
                endcase
                case ($urandom_range(0, 4))
                    0: item.select_mask = 32'hFFFF_FFFF;
                    1: item.select_mask = $urandom;
                    2: item.select_mask = 32'd1 << rnd[24:20];
                    3: item.select_mask = 32'h0000_0000;
                    default: item.select_mask = $urandom & $urandom;
                endcase
                send_item(item);
            end
        end
        s_valid <= 1'b0;

        // Drain the outstanding results, then allow for any late extra transfer.
        while (pending != 0)
            @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (errors == 0) begin
            $display("ordered_slot_table_unit test passed");
        end else begin
            $display("ordered_slot_table_unit test failed");
        end
        $finish;
    end

endmodule
